FILE: hdl/pfpes_pkg.sv
package pfpes_pkg;

	// default byte offset width
	localparam int ADDR_BITS_DEF = 18;

	// field widths
	localparam int CMD_W      = 2;
	localparam int DATA_W     = 8;
	localparam int KIND_W     = 2;
	localparam int WAIT_W     = 16;
	localparam int STATUS_W   = 3;
	localparam int PTRIES_W   = 8;
	localparam int ETRIES_W   = 10;
	localparam int US_W       = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// longest run of results for one item
	localparam int MAX_RESULTS = 6;
	localparam int CNT_W       = 3;

	// register reset values
	localparam logic [PTRIES_W-1:0] PROGRAM_TRIES_RST    = 8'd25;
	localparam logic [ETRIES_W-1:0] ERASE_TRIES_RST      = 10'd1000;
	localparam logic [US_W-1:0]     PROGRAM_PULSE_US_RST = 10'd10;
	localparam logic [US_W-1:0]     VERIFY_SETTLE_US_RST = 10'd6;
	localparam logic [WAIT_W-1:0]   ERASE_PULSE_US_RST   = 16'd10000;

	// flash command bytes
	localparam logic [DATA_W-1:0] FL_PROGRAM_SETUP  = 8'h40;
	localparam logic [DATA_W-1:0] FL_PROGRAM_VERIFY = 8'hc0;
	localparam logic [DATA_W-1:0] FL_ERASE          = 8'h20;
	localparam logic [DATA_W-1:0] FL_ERASE_VERIFY   = 8'ha0;
	localparam logic [DATA_W-1:0] FL_READ_RESET     = 8'h00;
	localparam logic [DATA_W-1:0] BYTE_ERASED       = 8'hff;
	localparam logic [DATA_W-1:0] BYTE_ZERO         = 8'h00;

	typedef enum logic [CMD_W-1:0] {
		CMD_PROGRAM  = 2'd0,
		CMD_ERASE    = 2'd1,
		CMD_READBACK = 2'd2
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE  = 2'd0,
		KIND_READ   = 2'd1,
		KIND_WAIT   = 2'd2,
		KIND_STATUS = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE         = 3'd0,
		ST_ACCEPTED     = 3'd1,
		ST_PROGRAM_FAIL = 3'd2,
		ST_ERASE_FAIL   = 3'd3,
		ST_UNEXPECTED   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROGRAM_TRIES    = 3'd0,
		CFG_ERASE_TRIES      = 3'd1,
		CFG_PROGRAM_PULSE_US = 3'd2,
		CFG_VERIFY_SETTLE_US = 3'd3,
		CFG_ERASE_PULSE_US   = 3'd4
	} cfg_idx_t;

endpackage

FILE: hdl/pfpes_ifs.sv
// command channel
interface pfpes_req_if import pfpes_pkg::*; #(parameter int ADDR_BITS = ADDR_BITS_DEF) ();
	logic                 valid;
	logic                 ready;
	logic [CMD_W-1:0]     command;
	logic [ADDR_BITS-1:0] address;
	logic [DATA_W-1:0]    data;
	logic                 last;
	logic [ADDR_BITS:0]   erase_size;

	modport source (output valid, command, address, data, last, erase_size, input ready);
	modport sink   (input valid, command, address, data, last, erase_size, output ready);
endinterface

// result channel
interface pfpes_rsp_if import pfpes_pkg::*; #(parameter int ADDR_BITS = ADDR_BITS_DEF) ();
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [ADDR_BITS-1:0] bus_address;
	logic [DATA_W-1:0]    bus_data;
	logic [WAIT_W-1:0]    wait_us;
	logic [STATUS_W-1:0]  status;
	logic                 run_end;

	modport source (output valid, kind, bus_address, bus_data, wait_us, status, run_end,
		input ready);
	modport sink   (input valid, kind, bus_address, bus_data, wait_us, status, run_end,
		output ready);
endinterface

// register write channel
interface pfpes_cfg_if import pfpes_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/parallel_flash_program_erase_sequencer.sv
// An accepted item is registered in the input register, then loads into the result shift
// register, whose head entry is offered; results leave one per cycle while rsp.ready holds.
// An item gives 1 to 6 results, and the shift register drains one entry per transfer.
// A new item is taken while the previous run drains; the next run loads as the last leaves.
// Reset (arst_n low, asynchronous) clears the sequencer state, empties both stages and
// restores the register defaults; no clearing pass is needed afterward.
module parallel_flash_program_erase_sequencer import pfpes_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pfpes_req_if.sink   req,
	pfpes_rsp_if.source rsp,
	pfpes_cfg_if.sink   cfg
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BURST,
		PH_PROG_READ,
		PH_ZERO_READ,
		PH_ERASE_READ
	} phase_t;

	typedef enum logic [2:0] {
		RUN_STATUS,
		RUN_FINISH,
		RUN_PROG,
		RUN_CHECK,
		RUN_PULSE_FINISH,
		RUN_PULSE_CHECK
	} run_t;

	typedef struct packed {
		kind_t                kind;
		logic [ADDR_BITS-1:0] addr;
		logic [DATA_W-1:0]    data;
		logic [WAIT_W-1:0]    wait_us;
		status_t              status;
	} res_t;

	function automatic res_t mk(kind_t k, logic [ADDR_BITS-1:0] a, logic [DATA_W-1:0] d,
			logic [WAIT_W-1:0] w, status_t s);
		res_t r;
		r.kind    = k;
		r.addr    = a;
		r.data    = d;
		r.wait_us = w;
		r.status  = s;
		return r;
	endfunction

	localparam logic [ADDR_BITS-1:0] ADDR_ZERO = '0;
	localparam logic [ADDR_BITS:0]   CHIP_CAP  = {1'b1, {ADDR_BITS{1'b0}}};
	localparam logic [ADDR_BITS:0]   ONE_WIDE  = {{ADDR_BITS{1'b0}}, 1'b1};

	// configuration registers
	logic [PTRIES_W-1:0] ptries_cfg_q;
	logic [ETRIES_W-1:0] etries_cfg_q;
	logic [US_W-1:0]     ppulse_cfg_q;
	logic [US_W-1:0]     settle_cfg_q;
	logic [WAIT_W-1:0]   epulse_cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptries_cfg_q <= PROGRAM_TRIES_RST;
			etries_cfg_q <= ERASE_TRIES_RST;
			ppulse_cfg_q <= PROGRAM_PULSE_US_RST;
			settle_cfg_q <= VERIFY_SETTLE_US_RST;
			epulse_cfg_q <= ERASE_PULSE_US_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_PROGRAM_TRIES:    ptries_cfg_q <= cfg.data[PTRIES_W-1:0];
				CFG_ERASE_TRIES:      etries_cfg_q <= cfg.data[ETRIES_W-1:0];
				CFG_PROGRAM_PULSE_US: ppulse_cfg_q <= cfg.data[US_W-1:0];
				CFG_VERIFY_SETTLE_US: settle_cfg_q <= cfg.data[US_W-1:0];
				CFG_ERASE_PULSE_US:   epulse_cfg_q <= cfg.data[WAIT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic                 v_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic [DATA_W-1:0]    data_s1;
	logic                 last_s1;
	logic [ADDR_BITS:0]   size_s1;
	logic                 load;
	logic                 run_free;

	logic [CNT_W-1:0] cnt_q;
	res_t             ent_q [MAX_RESULTS];
	logic             rsp_xfer;

	assign rsp_xfer  = rsp.valid & rsp.ready;
	assign run_free  = (cnt_q == '0) || (cnt_q == CNT_W'(1) && rsp_xfer);
	assign load      = v_s1 & run_free;
	assign req.ready = ~v_s1 | load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1  <= req.command;
			addr_s1 <= req.address;
			data_s1 <= req.data;
			last_s1 <= req.last;
			size_s1 <= req.erase_size;
		end
	end

	// sequencer state
	phase_t               phase_q, phase_d;
	logic [ADDR_BITS-1:0] off_q, off_d;
	logic [DATA_W-1:0]    byte_q, byte_d;
	logic [PTRIES_W-1:0]  pleft_q, pleft_d;
	logic [ETRIES_W-1:0]  eleft_q, eleft_d;
	logic [ADDR_BITS:0]   chip_q, chip_d;
	logic                 bend_q, bend_d;

	// decode of one item against the state
	run_t                 run;
	logic [ADDR_BITS-1:0] r_addr;
	logic [DATA_W-1:0]    r_data;
	status_t              r_st;

	logic                 waiting;
	logic [ADDR_BITS:0]   off_inc;
	logic                 more_bytes;
	logic [PTRIES_W-1:0]  pleft_dec;
	logic [ETRIES_W-1:0]  eleft_dec;
	logic [PTRIES_W-1:0]  ptries_load;
	logic [ETRIES_W-1:0]  etries_load;
	logic [ADDR_BITS:0]   size_cap;

	assign waiting     = (phase_q == PH_PROG_READ) || (phase_q == PH_ZERO_READ) ||
		(phase_q == PH_ERASE_READ);
	assign off_inc     = {1'b0, off_q} + ONE_WIDE;
	assign more_bytes  = off_inc < chip_q;
	assign pleft_dec   = pleft_q - PTRIES_W'(1);
	assign eleft_dec   = eleft_q - ETRIES_W'(1);
	assign ptries_load = (ptries_cfg_q != '0) ? ptries_cfg_q : PTRIES_W'(1);
	assign etries_load = (etries_cfg_q != '0) ? etries_cfg_q : ETRIES_W'(1);
	assign size_cap    = size_s1[ADDR_BITS] ? CHIP_CAP : size_s1;

	always_comb begin
		phase_d = phase_q;
		off_d   = off_q;
		byte_d  = byte_q;
		pleft_d = pleft_q;
		eleft_d = eleft_q;
		chip_d  = chip_q;
		bend_d  = bend_q;
		run     = RUN_STATUS;
		r_addr  = ADDR_ZERO;
		r_data  = BYTE_ZERO;
		r_st    = ST_UNEXPECTED;

		if (cmd_s1 == CMD_PROGRAM && !waiting) begin
			// start programming one byte, skip an erased value
			off_d  = addr_s1;
			bend_d = last_s1;
			if (data_s1 == BYTE_ERASED) begin
				if (last_s1) begin
					run     = RUN_FINISH;
					r_st    = ST_DONE;
					phase_d = PH_IDLE;
				end else begin
					run     = RUN_STATUS;
					r_addr  = addr_s1;
					r_st    = ST_ACCEPTED;
					phase_d = PH_BURST;
				end
			end else begin
				byte_d  = data_s1;
				pleft_d = ptries_load;
				run     = RUN_PROG;
				r_addr  = addr_s1;
				r_data  = data_s1;
				phase_d = PH_PROG_READ;
			end
		end else if (cmd_s1 == CMD_ERASE && phase_q == PH_IDLE) begin
			// erase starts by zeroing the first byte; a zero size gets one erase pulse and finishes
			chip_d = size_cap;
			off_d  = ADDR_ZERO;
			byte_d = BYTE_ZERO;
			if (size_cap == '0) begin
				eleft_d = etries_load;
				run     = RUN_PULSE_FINISH;
				r_st    = ST_DONE;
				phase_d = PH_IDLE;
			end else begin
				pleft_d = ptries_load;
				run     = RUN_PROG;
				phase_d = PH_ZERO_READ;
			end
		end else if (cmd_s1 == CMD_READBACK && phase_q == PH_PROG_READ) begin
			// verify a programmed byte
			if (data_s1 == byte_q) begin
				if (bend_q) begin
					run     = RUN_FINISH;
					r_st    = ST_DONE;
					phase_d = PH_IDLE;
				end else begin
					run     = RUN_STATUS;
					r_addr  = off_q;
					r_st    = ST_ACCEPTED;
					phase_d = PH_BURST;
				end
			end else begin
				pleft_d = pleft_dec;
				if (pleft_dec != '0) begin
					run    = RUN_PROG;
					r_addr = off_q;
					r_data = byte_q;
				end else begin
					run     = RUN_FINISH;
					r_addr  = off_q;
					r_st    = ST_PROGRAM_FAIL;
					phase_d = PH_IDLE;
				end
			end
		end else if (cmd_s1 == CMD_READBACK && phase_q == PH_ZERO_READ) begin
			// verify a zeroed byte, then move on, retry, fail or start erase pulses
			if (data_s1 == BYTE_ZERO) begin
				if (more_bytes) begin
					off_d   = off_inc[ADDR_BITS-1:0];
					pleft_d = ptries_load;
					run     = RUN_PROG;
					r_addr  = off_inc[ADDR_BITS-1:0];
				end else begin
					off_d   = ADDR_ZERO;
					eleft_d = etries_load;
					run     = RUN_PULSE_CHECK;
					phase_d = PH_ERASE_READ;
				end
			end else begin
				pleft_d = pleft_dec;
				if (pleft_dec != '0) begin
					run    = RUN_PROG;
					r_addr = off_q;
				end else begin
					run     = RUN_FINISH;
					r_addr  = off_q;
					r_st    = ST_PROGRAM_FAIL;
					phase_d = PH_IDLE;
				end
			end
		end else if (cmd_s1 == CMD_READBACK && phase_q == PH_ERASE_READ) begin
			// erase verify, resume at the failing byte after a new pulse, or fail when tries run out
			if (data_s1 == BYTE_ERASED) begin
				if (more_bytes) begin
					off_d  = off_inc[ADDR_BITS-1:0];
					run    = RUN_CHECK;
					r_addr = off_inc[ADDR_BITS-1:0];
				end else begin
					run     = RUN_FINISH;
					r_st    = ST_DONE;
					phase_d = PH_IDLE;
				end
			end else begin
				eleft_d = eleft_dec;
				if (eleft_dec != '0) begin
					run    = RUN_PULSE_CHECK;
					r_addr = off_q;
				end else begin
					run     = RUN_FINISH;
					r_addr  = off_q;
					r_st    = ST_ERASE_FAIL;
					phase_d = PH_IDLE;
				end
			end
		end
	end

	// expand the run into result entries
	res_t             ent_d [MAX_RESULTS];
	logic [CNT_W-1:0] cnt_d;

	always_comb begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			ent_d[i] = '0;
		end
		cnt_d = CNT_W'(1);
		unique case (run)
			RUN_STATUS: begin
				ent_d[0] = mk(KIND_STATUS, r_addr, BYTE_ZERO, '0, r_st);
				cnt_d    = CNT_W'(1);
			end
			RUN_FINISH: begin
				ent_d[0] = mk(KIND_WRITE, ADDR_ZERO, FL_READ_RESET, '0, ST_DONE);
				ent_d[1] = mk(KIND_STATUS, r_addr, BYTE_ZERO, '0, r_st);
				cnt_d    = CNT_W'(2);
			end
			RUN_PROG: begin
				ent_d[0] = mk(KIND_WRITE, ADDR_ZERO, FL_PROGRAM_SETUP, '0, ST_DONE);
				ent_d[1] = mk(KIND_WRITE, r_addr, r_data, '0, ST_DONE);
				ent_d[2] = mk(KIND_WAIT, ADDR_ZERO, BYTE_ZERO, WAIT_W'(ppulse_cfg_q), ST_DONE);
				ent_d[3] = mk(KIND_WRITE, ADDR_ZERO, FL_PROGRAM_VERIFY, '0, ST_DONE);
				ent_d[4] = mk(KIND_WAIT, ADDR_ZERO, BYTE_ZERO, WAIT_W'(settle_cfg_q), ST_DONE);
				ent_d[5] = mk(KIND_READ, ADDR_ZERO, BYTE_ZERO, '0, ST_DONE);
				cnt_d    = CNT_W'(6);
			end
			RUN_CHECK: begin
				ent_d[0] = mk(KIND_WRITE, r_addr, FL_ERASE_VERIFY, '0, ST_DONE);
				ent_d[1] = mk(KIND_WAIT, ADDR_ZERO, BYTE_ZERO, WAIT_W'(settle_cfg_q), ST_DONE);
				ent_d[2] = mk(KIND_READ, ADDR_ZERO, BYTE_ZERO, '0, ST_DONE);
				cnt_d    = CNT_W'(3);
			end
			RUN_PULSE_FINISH: begin
				ent_d[0] = mk(KIND_WRITE, ADDR_ZERO, FL_ERASE, '0, ST_DONE);
				ent_d[1] = mk(KIND_WRITE, ADDR_ZERO, FL_ERASE, '0, ST_DONE);
				ent_d[2] = mk(KIND_WAIT, ADDR_ZERO, BYTE_ZERO, epulse_cfg_q, ST_DONE);
				ent_d[3] = mk(KIND_WRITE, ADDR_ZERO, FL_READ_RESET, '0, ST_DONE);
				ent_d[4] = mk(KIND_STATUS, ADDR_ZERO, BYTE_ZERO, '0, r_st);
				cnt_d    = CNT_W'(5);
			end
			RUN_PULSE_CHECK: begin
				ent_d[0] = mk(KIND_WRITE, ADDR_ZERO, FL_ERASE, '0, ST_DONE);
				ent_d[1] = mk(KIND_WRITE, ADDR_ZERO, FL_ERASE, '0, ST_DONE);
				ent_d[2] = mk(KIND_WAIT, ADDR_ZERO, BYTE_ZERO, epulse_cfg_q, ST_DONE);
				ent_d[3] = mk(KIND_WRITE, r_addr, FL_ERASE_VERIFY, '0, ST_DONE);
				ent_d[4] = mk(KIND_WAIT, ADDR_ZERO, BYTE_ZERO, WAIT_W'(settle_cfg_q), ST_DONE);
				ent_d[5] = mk(KIND_READ, ADDR_ZERO, BYTE_ZERO, '0, ST_DONE);
				cnt_d    = CNT_W'(6);
			end
			default: ;
		endcase
	end

	// state update as an item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			off_q   <= '0;
			byte_q  <= '0;
			pleft_q <= '0;
			eleft_q <= '0;
			chip_q  <= '0;
			bend_q  <= 1'b0;
		end else if (load) begin
			phase_q <= phase_d;
			off_q   <= off_d;
			byte_q  <= byte_d;
			pleft_q <= pleft_d;
			eleft_q <= eleft_d;
			chip_q  <= chip_d;
			bend_q  <= bend_d;
		end
	end

	// result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= cnt_d;
		end else if (rsp_xfer) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// result shift register, head entry is offered
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				ent_q[i] <= ent_d[i];
			end
		end else if (rsp_xfer) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
			ent_q[MAX_RESULTS-1] <= '0;
		end
	end

	assign rsp.valid       = cnt_q != '0;
	assign rsp.kind        = ent_q[0].kind;
	assign rsp.bus_address = ent_q[0].addr;
	assign rsp.bus_data    = ent_q[0].data;
	assign rsp.wait_us     = ent_q[0].wait_us;
	assign rsp.status      = ent_q[0].status;
	assign rsp.run_end     = cnt_q == CNT_W'(1);

endmodule

FILE: hdl/pfpes_chk.sv
module pfpes_chk import pfpes_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [KIND_W-1:0]    rsp_kind,
	input logic [ADDR_BITS-1:0] rsp_bus_address,
	input logic [DATA_W-1:0]    rsp_bus_data,
	input logic [WAIT_W-1:0]    rsp_wait_us,
	input logic [STATUS_W-1:0]  rsp_status,
	input logic                 rsp_run_end
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
		$stable(rsp_bus_address) && $stable(rsp_bus_data) && $stable(rsp_wait_us) &&
		$stable(rsp_status) && $stable(rsp_run_end))
		else $error("result changed while stalled");

	// a status always closes its run
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_STATUS |-> rsp_run_end)
		else $error("status not at end of run");

	// a read is at offset zero with zero data and closes its run
	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_READ |-> rsp_run_end && rsp_bus_address == '0 &&
		rsp_bus_data == '0)
		else $error("bus read misplaced");

	// outside status, only waits carry a length; only status carries a code
	a_fields_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind != KIND_STATUS |-> rsp_status == ST_DONE &&
		(rsp_kind == KIND_WAIT || rsp_wait_us == '0))
		else $error("stray field value");

endmodule

bind parallel_flash_program_erase_sequencer pfpes_chk #(.ADDR_BITS(ADDR_BITS)) u_pfpes_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_kind        (rsp.kind),
	.rsp_bus_address (rsp.bus_address),
	.rsp_bus_data    (rsp.bus_data),
	.rsp_wait_us     (rsp.wait_us),
	.rsp_status      (rsp.status),
	.rsp_run_end     (rsp.run_end)
);
